// File: src/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared constants, command codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package stb_pkg;

   localparam int SLOTS       = 8;
   localparam int MAX_RESULTS = 8;
   localparam int SLOT_IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NRES_W      = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

   localparam logic [31:0] ELAPSED_LIMIT = 32'hEFFF_FFFF;
   localparam logic [7:0]  NO_SLOT       = 8'hFF;
   localparam logic [7:0]  SLOTS_LIMIT   = 8'(SLOTS);

   localparam logic [SLOT_IW-1:0] LAST_SLOT = SLOT_IW'(SLOTS - 1);
   localparam logic [NRES_W-1:0]  LAST_RES  = NRES_W'(MAX_RESULTS - 1);

   localparam logic [2:0] FUNC_TICK   = 3'd0;
   localparam logic [2:0] FUNC_CREATE = 3'd1;
   localparam logic [2:0] FUNC_DELETE = 3'd2;
   localparam logic [2:0] FUNC_START  = 3'd3;
   localparam logic [2:0] FUNC_STOP   = 3'd4;
   localparam logic [2:0] FUNC_RESET  = 3'd5;
   localparam logic [2:0] FUNC_READ   = 3'd6;
   localparam logic [2:0] FUNC_CLEAR  = 3'd7;

   // controller -> datapath
   typedef struct packed {
      logic               exec;       // request accepted: latch, run the ops done at acceptance
      logic               walk;       // advance timer at idx
      logic               load_fire;  // output fire result for idx
      logic               alloc;      // claim slot idx, output create result
      logic               load_none;  // output create failure
      logic               load_read;  // output elapsed counter
      logic               last;       // tlast for the loaded result
      logic [SLOT_IW-1:0] idx;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic cur_free;     // slot idx not in use
      logic cur_fire;     // slot idx fired on this tick
      logic rest_empty;   // no fired slot above idx
      logic out_free;     // output register can take a result
   } status_type;

endpackage

// File: src/stb_datapath.sv
// ----------------------------------------------------------------------------
// stb_datapath
// Timer slot storage, millisecond counter, fire flags and result register.
// ----------------------------------------------------------------------------
module stb_datapath
   import stb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_slot_index,
   input  logic        req_one_shot,
   input  logic [31:0] req_preload,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_slot,
   output logic        rsp_fired,
   output logic        rsp_alloc_ok,
   output logic [31:0] rsp_elapsed,
   output logic        rsp_tlast
);

   logic [31:0]        elapsed_ff, elapsed_in;
   logic [SLOTS-1:0]   use_ff, use_in;
   logic [SLOTS-1:0]   en_ff, en_in;
   logic [SLOTS-1:0]   os_ff, os_in;
   logic [SLOTS-1:0]   fire_ff, fire_in;
   logic [31:0]        count_ff [SLOTS];
   logic [31:0]        preload_ff [SLOTS];
   logic               req_os_ff;
   logic [31:0]        req_preload_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_slot_ff, rsp_slot_in;
   logic               rsp_fired_ff, rsp_fired_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [31:0]        rsp_elapsed_ff, rsp_elapsed_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               idx_ok;
   logic [SLOT_IW-1:0] ridx;
   logic [31:0]        cnt_inc;
   logic               active, hit;
   logic               count_we;
   logic [SLOT_IW-1:0] count_wa;
   logic [31:0]        count_in;
   logic [SLOTS-1:0]   rest;
   logic               load;

   assign idx_ok  = req_slot_index < SLOTS_LIMIT;
   assign ridx    = req_slot_index[SLOT_IW-1:0];
   assign active  = use_ff[cmd.idx] && en_ff[cmd.idx];
   assign cnt_inc = count_ff[cmd.idx] + 32'd1;
   assign hit     = cnt_inc == preload_ff[cmd.idx];

   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         rest[j] = fire_ff[j] && (j > int'(cmd.idx));
      end
   end

   assign load              = cmd.load_fire || cmd.alloc || cmd.load_none || cmd.load_read;
   assign status.cur_free   = !use_ff[cmd.idx];
   assign status.cur_fire   = fire_ff[cmd.idx];
   assign status.rest_empty = rest == '0;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   // flag vectors and counter
   always_comb begin
      elapsed_in = elapsed_ff;
      use_in     = use_ff;
      en_in      = en_ff;
      os_in      = os_ff;
      fire_in    = fire_ff;
      if (cmd.exec) begin
         unique case (req_func)
            FUNC_TICK: begin
               elapsed_in = ((elapsed_ff > ELAPSED_LIMIT) ? 32'd0 : elapsed_ff) + 32'd1;
               fire_in    = '0;
            end
            FUNC_DELETE: begin
               if (idx_ok) begin
                  use_in[ridx] = 1'b0;
                  en_in[ridx]  = 1'b0;
               end
            end
            FUNC_START: begin
               if (idx_ok && use_ff[ridx]) en_in[ridx] = 1'b1;
            end
            FUNC_STOP: begin
               if (idx_ok) en_in[ridx] = 1'b0;
            end
            FUNC_CLEAR: begin
               elapsed_in = '0;
            end
            default: begin
            end
         endcase
      end
      if (cmd.walk && active && hit) begin
         fire_in[cmd.idx] = 1'b1;
         if (os_ff[cmd.idx]) en_in[cmd.idx] = 1'b0;
      end
      if (cmd.alloc) begin
         use_in[cmd.idx] = 1'b1;
         en_in[cmd.idx]  = 1'b0;
         os_in[cmd.idx]  = req_os_ff;
      end
   end

   // single write port for the count store
   always_comb begin
      count_we = 1'b0;
      count_wa = cmd.idx;
      count_in = '0;
      if (cmd.exec && req_func == FUNC_RESET && idx_ok) begin
         count_we = 1'b1;
         count_wa = ridx;
      end else if (cmd.walk && active) begin
         count_we = 1'b1;
         count_in = hit ? 32'd0 : cnt_inc;
      end else if (cmd.alloc) begin
         count_we = 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_slot_in    = rsp_slot_ff;
      rsp_fired_in   = rsp_fired_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      rsp_last_in    = rsp_last_ff;
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_slot_in    = cmd.load_none ? NO_SLOT :
                          cmd.load_read ? 8'd0 : 8'(cmd.idx);
         rsp_fired_in   = cmd.load_fire;
         rsp_ok_in      = cmd.alloc;
         rsp_elapsed_in = cmd.load_read ? elapsed_ff : 32'd0;
         rsp_last_in    = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         use_ff       <= '0;
         en_ff        <= '0;
         os_ff        <= '0;
         fire_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         elapsed_ff   <= elapsed_in;
         use_ff       <= use_in;
         en_ff        <= en_in;
         os_ff        <= os_in;
         fire_ff      <= fire_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (count_we) count_ff[count_wa] <= count_in;
      if (cmd.alloc) preload_ff[cmd.idx] <= req_preload_ff;
      if (cmd.exec) begin
         req_os_ff      <= req_one_shot;
         req_preload_ff <= req_preload;
      end
      rsp_slot_ff    <= rsp_slot_in;
      rsp_fired_ff   <= rsp_fired_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_fired    = rsp_fired_ff;
   assign rsp_alloc_ok = rsp_ok_ff;
   assign rsp_elapsed  = rsp_elapsed_ff;
   assign rsp_tlast    = rsp_last_ff;

endmodule

// File: src/stb_ctrl.sv
// ----------------------------------------------------------------------------
// stb_ctrl
// Sequencer: takes requests, walks slots for tick and create, scans fires.
// ----------------------------------------------------------------------------
module stb_ctrl
   import stb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [2:0] req_func,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_WALK = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_FIND = 3'd3;
   localparam logic [2:0] S_READ = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [SLOT_IW-1:0] idx_ff, idx_in;
   logic [NRES_W-1:0]  nres_ff, nres_in;
   logic               at_last;
   logic               res_last;

   assign at_last    = idx_ff == LAST_SLOT;
   assign res_last   = status.rest_empty || nres_ff == LAST_RES;
   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      nres_in  = nres_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.exec = 1'b1;
               idx_in   = '0;
               nres_in  = '0;
               case (req_func)
                  FUNC_TICK:   state_in = S_WALK;
                  FUNC_CREATE: state_in = S_FIND;
                  FUNC_READ:   state_in = S_READ;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (at_last) begin
               idx_in   = '0;
               state_in = S_SCAN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SCAN: begin
            if (status.cur_fire) begin
               if (status.out_free) begin
                  cmd.load_fire = 1'b1;
                  cmd.last      = res_last;
                  nres_in       = nres_ff + 1'b1;
                  if (res_last || at_last) state_in = S_IDLE;
                  else idx_in = idx_ff + 1'b1;
               end
            end else if (at_last) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FIND: begin
            if (status.cur_free) begin
               if (status.out_free) begin
                  cmd.alloc = 1'b1;
                  cmd.last  = 1'b1;
                  state_in  = S_IDLE;
               end
            end else if (at_last) begin
               if (status.out_free) begin
                  cmd.load_none = 1'b1;
                  cmd.last      = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_READ: begin
            if (status.out_free) begin
               cmd.load_read = 1'b1;
               cmd.last      = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         nres_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         nres_ff  <= nres_in;
      end
   end

endmodule

// File: src/soft_timer_bank_core.sv
// ----------------------------------------------------------------------------
// soft_timer_bank_core
// Bank of software timers with a millisecond counter advanced by each tick request.
// ----------------------------------------------------------------------------
//
// channel  dir  tdata (low bit up)                           tuser     tlast
// req      in   slot_index[7:0] one_shot[8] preload[40:9]   func[2:0] -
// rsp      out  slot[7:0] alloc_ok[8] elapsed[40:9]         fired     last
//
// Sequence: delete/start/stop/reset count/clear elapsed finish when the request
// is taken; read then loads the counter; create walks for the lowest free slot;
// tick walks one slot per cycle through the count adder and compare, then
// scans the fire flags one slot per cycle (the scan stops at the last fired
// slot). A waiting result adds stalls.
// Reset: synchronous, active high; clears counter and all slot flags.
// Stalls: a result register parts the channels; a request is taken while the
// last result still waits, and the sequencer holds while the register is full.
//
module soft_timer_bank_core
   import stb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // slot_index[7:0], one_shot[8], preload[40:9]
   input  logic [2:0]  req_tuser,   // func[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // slot[7:0], alloc_ok[8], elapsed[40:9]
   output logic        rsp_tuser,   // fired
   output logic        rsp_tlast
);

   cmd_type     cmd;
   status_type  status;
   logic [7:0]  rsp_slot;
   logic        rsp_alloc_ok;
   logic [31:0] rsp_elapsed;

   stb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   stb_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req_tuser),
      .req_slot_index (req_tdata[7:0]),
      .req_one_shot   (req_tdata[8]),
      .req_preload    (req_tdata[40:9]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_slot       (rsp_slot),
      .rsp_fired      (rsp_tuser),
      .rsp_alloc_ok   (rsp_alloc_ok),
      .rsp_elapsed    (rsp_elapsed),
      .rsp_tlast      (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, rsp_elapsed, rsp_alloc_ok, rsp_slot};

   // a result is only loaded into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_fire || cmd.alloc || cmd.load_none || cmd.load_read) |->
      (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a pending result");

   // fire and allocation reports never mix
   a_fire_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (!rsp_tdata[8] && rsp_tdata[40:9] == 32'd0))
      else $error("fire result carries create or read fields");

   // create and read answer with a single result
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("non-fire result without tlast");

   // a new request is only taken with no walk, fire or create command active
   a_exec_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !(cmd.walk || cmd.load_fire || cmd.alloc || cmd.load_none))
      else $error("request accepted while sequencer busy");

endmodule
